### src/lzwe_pkg.sv
// Package: shared constants, opcodes and structs of the LZW encoder.
package lzwe_pkg;

    localparam int LZWE_DICT_SIZE = 4096;
    localparam int MAX_CODE_W     = 16;
    localparam int MAX_WIDTH_W    = 5;
    localparam int RES_MAX        = 3;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Up to three packed bytes produced by one input item.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [1:0]              n;
    } bundle_t;

    // Result of packing one code into the byte stream.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two_bytes;
        logic [7:0] pb_new;
        logic [2:0] pbits_new;
    } pack_t;

endpackage

### src/lzwe_if.sv
// Interfaces: input item channel and packed byte channel.
interface lzwe_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface lzwe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_run;

    modport source (output valid, output packed_byte, output last_of_run, input ready);
    modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

### src/lzw_encoder_variable_width.sv
// Top level: LZW encoder with growing code width and byte packing.
//
// Usage:
//   symbols: input transactions, opcode 0 carries a data byte, opcode 1 closes
//   the stream (emit the pending code, flush the zero-padded partial byte).
//   codes: output transactions, one packed byte each; last_of_run marks the
//   final byte that one input transaction produced. A transaction may produce
//   no bytes (matched prefix, close with nothing pending).
// Timing:
//   After reset the child table memory is swept to empty, all DICT_SIZE*256
//   entries; symbols.ready stays low meanwhile.
//   An accepted item's table read is issued and registered in the acceptance
//   cycle; in the next cycle its bundle is pushed into the result queue,
//   and its bytes reach codes.valid once registered there.
//   One item is accepted per cycle while the result queue has room; the
//   table lookup of item k+1 uses the prefix resolved from item k's read in
//   the same cycle, with the just-written entry forwarded. Sustained output
//   is one byte per cycle while codes.ready is high, so a long run of
//   misses is paced by the bytes each code produces (one or two per code).
// Stalls:
//   When codes.ready is low, hold bytes in a four-bundle queue; once the
//   queue lacks room for the bundle still in lookup plus one more, drop
//   symbols.ready.
module lzw_encoder_variable_width
    import lzwe_pkg::*;
#(
    parameter int DICT_SIZE = LZWE_DICT_SIZE
)
(
    input  logic        clk,
    input  logic        rst_n,
    lzwe_in_if.sink     symbols,
    lzwe_out_if.source  codes
);

    localparam int CODE_W  = $clog2(DICT_SIZE);
    localparam int NFC_W   = $clog2(DICT_SIZE + 1);
    localparam int WIDTH_W = $clog2(CODE_W + 1);
    localparam int ADDR_W  = CODE_W + 8;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Lookup stage: the item whose table read is in flight.
    logic               b_valid_reg;
    logic               b_op_reg;
    logic [7:0]         b_data_reg;

    // Encoder state.
    logic [CODE_W-1:0]  cur_code_reg,  cur_code_next;
    logic               have_prefix_reg, have_prefix_next;
    logic [NFC_W-1:0]   nfc_reg,       nfc_next;
    logic [WIDTH_W-1:0] width_reg,     width_next;
    logic [7:0]         pb_reg,        pb_next;
    logic [2:0]         pbits_reg,     pbits_next;

    logic               dict_busy;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [CODE_W-1:0]  kid;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CODE_W-1:0]  wr_data;

    logic               push;
    bundle_t            bundle;
    logic [QCNT_W-1:0]  q_count;
    logic [QCNT_W-1:0]  q_limit;
    logic               accept;
    logic               hit;
    pack_t              pk;

    // Keep room for the bundle of the item in lookup and of the new one.
    assign q_limit       = b_valid_reg ? QCNT_W'(QUEUE_DEPTH - 2) : QCNT_W'(QUEUE_DEPTH - 1);
    assign symbols.ready = !dict_busy && (q_count <= q_limit);
    assign accept        = symbols.valid && symbols.ready;

    // Issue the next lookup keyed by the prefix resolved this cycle.
    assign rd_en   = accept;
    assign rd_addr = {cur_code_next, symbols.data_byte};

    lzwe_dict #(
        .DICT_SIZE (DICT_SIZE)
    ) u_dict (
        .clk     (clk),
        .rst_n   (rst_n),
        .busy    (dict_busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (kid),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lzwe_pack u_pack (
        .code_value   (MAX_CODE_W'(cur_code_reg)),
        .code_width   (MAX_WIDTH_W'(width_reg)),
        .partial_byte (pb_reg),
        .partial_bits (pbits_reg),
        .result       (pk)
    );

    lzwe_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .bundle (bundle),
        .count  (q_count),
        .codes  (codes)
    );

    assign hit = (kid != '0);

    always_comb
    begin
        cur_code_next    = cur_code_reg;
        have_prefix_next = have_prefix_reg;
        nfc_next         = nfc_reg;
        width_next       = width_reg;
        pb_next          = pb_reg;
        pbits_next       = pbits_reg;
        wr_en            = 1'b0;
        wr_addr          = {cur_code_reg, b_data_reg};
        wr_data          = nfc_reg[CODE_W-1:0];
        bundle           = '0;

        if (b_valid_reg)
        begin
            if (b_op_reg == OP_DATA)
            begin
                if (!have_prefix_reg)
                begin
                    // First byte at root: it becomes the prefix, nothing goes out.
                    cur_code_next    = CODE_W'(b_data_reg);
                    have_prefix_next = 1'b1;
                end
                else if (hit)
                begin
                    cur_code_next = kid;
                end
                else
                begin
                    bundle.bytes[0] = pk.byte0;
                    bundle.bytes[1] = pk.byte1;
                    bundle.n        = pk.two_bytes ? 2'd2 : 2'd1;
                    pb_next         = pk.pb_new;
                    pbits_next      = pk.pbits_new;
                    // Add the new string while codes remain; widen on a power of two.
                    if (nfc_reg < NFC_W'(DICT_SIZE))
                    begin
                        wr_en    = 1'b1;
                        nfc_next = nfc_reg + 1'b1;
                        if ((nfc_reg & (nfc_reg - 1'b1)) == '0)
                        begin
                            width_next = width_reg + 1'b1;
                        end
                    end
                    cur_code_next = CODE_W'(b_data_reg);
                end
            end
            else
            begin
                if (have_prefix_reg)
                begin
                    bundle.bytes[0] = pk.byte0;
                    if (pk.two_bytes)
                    begin
                        bundle.bytes[1] = pk.byte1;
                        bundle.bytes[2] = pk.pb_new;
                        bundle.n        = (pk.pbits_new != '0) ? 2'd3 : 2'd2;
                    end
                    else
                    begin
                        bundle.bytes[1] = pk.pb_new;
                        bundle.n        = (pk.pbits_new != '0) ? 2'd2 : 2'd1;
                    end
                end
                else if (pbits_reg != '0)
                begin
                    bundle.bytes[0] = pb_reg;
                    bundle.n        = 2'd1;
                end
                // Return to root with an empty partial byte; keep the table.
                cur_code_next    = '0;
                have_prefix_next = 1'b0;
                pb_next          = '0;
                pbits_next       = '0;
            end
        end
    end

    assign push = (bundle.n != 2'd0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_op_reg   <= symbols.opcode;
            b_data_reg <= symbols.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            cur_code_reg    <= '0;
            have_prefix_reg <= 1'b0;
            nfc_reg         <= NFC_W'(256);
            width_reg       <= WIDTH_W'(8);
            pb_reg          <= '0;
            pbits_reg       <= '0;
        end
        else
        begin
            b_valid_reg     <= accept;
            cur_code_reg    <= cur_code_next;
            have_prefix_reg <= have_prefix_next;
            nfc_reg         <= nfc_next;
            width_reg       <= width_next;
            pb_reg          <= pb_next;
            pbits_reg       <= pbits_next;
        end
    end

endmodule

### src/lzwe_dict.sv
// Child table memory with a clearing pass after reset and write-to-read forwarding.
module lzwe_dict
    import lzwe_pkg::*;
#(
    parameter int DICT_SIZE = LZWE_DICT_SIZE
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    output logic                               busy,
    input  logic                               rd_en,
    input  logic [$clog2(DICT_SIZE)+7:0]       rd_addr,
    output logic [$clog2(DICT_SIZE)-1:0]       rd_data,
    input  logic                               wr_en,
    input  logic [$clog2(DICT_SIZE)+7:0]       wr_addr,
    input  logic [$clog2(DICT_SIZE)-1:0]       wr_data
);

    localparam int CODE_W = $clog2(DICT_SIZE);
    localparam int ADDR_W = CODE_W + 8;
    localparam int DEPTH  = DICT_SIZE * 256;

    logic [CODE_W-1:0] mem [DEPTH];

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              fwd_reg;
    logic [CODE_W-1:0] fwd_data_reg;
    logic [CODE_W-1:0] rd_q_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CODE_W-1:0] mem_wdata;

    assign busy = clr_busy_reg;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Sweep every entry to empty, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (rd_en)
            begin
                fwd_reg <= wr_en && !clr_busy_reg && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

### src/lzwe_pack.sv
// Bit packer: splits one code into completed bytes and a new partial byte.
module lzwe_pack
    import lzwe_pkg::*;
(
    input  logic [MAX_CODE_W-1:0]  code_value,
    input  logic [MAX_WIDTH_W-1:0] code_width,
    input  logic [7:0]             partial_byte,
    input  logic [2:0]             partial_bits,
    output pack_t                  result
);

    logic [3:0]            room;
    logic [MAX_WIDTH_W-1:0] left;
    logic [MAX_CODE_W-1:0] vshift;
    logic [MAX_CODE_W-1:0] rem_val;
    logic [2:0]            rem;
    logic [3:0]            rem_gap;

    always_comb
    begin
        room    = 4'd8 - {1'b0, partial_bits};
        left    = code_width - MAX_WIDTH_W'(room);
        vshift  = code_value >> room;

        result.byte0     = partial_byte | (code_value[7:0] & (8'hFF >> (4'd8 - room)));
        result.byte1     = vshift[7:0];
        result.two_bytes = (left >= MAX_WIDTH_W'(8));

        if (result.two_bytes)
        begin
            rem_val = vshift >> 8;
            rem     = left[2:0];
        end
        else
        begin
            rem_val = vshift;
            rem     = left[2:0];
        end

        // Leftover bits sit at the top of the new partial byte.
        rem_gap          = 4'd8 - {1'b0, rem};
        result.pb_new    = (rem_val[7:0] & (8'hFF >> rem_gap)) << rem_gap;
        result.pbits_new = rem;
    end

endmodule

### src/lzwe_outq.sv
// Result queue: holds byte bundles and serializes them onto the byte channel.
module lzwe_outq
    import lzwe_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  bundle_t                            bundle,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
    lzwe_out_if.source                         codes
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [1:0]          idx_reg;

    bundle_t head;
    logic    last;
    logic    take;
    logic    pop;

    assign head  = q_reg[rd_ptr_reg];
    assign last  = (idx_reg == (head.n - 2'd1));
    assign take  = codes.valid && codes.ready;
    assign pop   = take && last;
    assign count = count_reg;

    assign codes.valid       = (count_reg != '0);
    assign codes.packed_byte = head.bytes[idx_reg];
    assign codes.last_of_run = last;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                if (last)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    idx_reg    <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

### src/lzwe_checker.sv
// Checker: port-level assertions for the LZW encoder, bound to the top level.
module lzwe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic seen_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_in_reg <= 1'b1;
        end
    end

    // Table sweep holds off input right after reset.
    a_no_accept_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("input ready right after reset");

    a_no_output_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    a_output_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_in_reg)
        else $error("output byte without any input transaction");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output changed");

endmodule

bind lzw_encoder_variable_width lzwe_checker u_lzwe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (symbols.valid),
    .in_ready  (symbols.ready),
    .out_valid (codes.valid),
    .out_ready (codes.ready),
    .out_byte  (codes.packed_byte),
    .out_last  (codes.last_of_run)
);
